// ----- src/egcd_pkg.sv -----
// Shared types for the extended gcd block: sequencer states and control/status bundles.
package egcd_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCALE,
    ST_REDUCE,
    ST_DONE
  } egcd_state_t;

  // Commands from the sequencer to the shift-subtract unit
  typedef struct packed {
    logic load;    // capture operands, initialise coefficient pairs
    logic start;   // clear the shift count for a new quotient
    logic scale;   // raise the shift count by one
    logic reduce;  // conditional subtract at the current shift, then step down or swap
  } egcd_ctrl_t;

  // Status from the shift-subtract unit to the sequencer
  typedef struct packed {
    logic cur_zero;  // current remainder is zero: the algorithm has finished
    logic scale_ok;  // divisor shifted once more still fits under the remainder
    logic k_zero;    // shift count has reached zero
  } egcd_status_t;

endpackage

// ----- src/egcd_unit.sv -----
// Shift-subtract unit of the extended gcd: remainders, coefficient pairs and shift count.
module egcd_unit import egcd_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  egcd_ctrl_t                 ctrl,
  input  logic [OPERAND_WIDTH-2:0]   first_value,
  input  logic [OPERAND_WIDTH-2:0]   second_value,
  output egcd_status_t               status,
  output logic [OPERAND_WIDTH-2:0]   divisor,
  output logic [OPERAND_WIDTH-1:0]   coef_first,
  output logic [OPERAND_WIDTH-1:0]   coef_second
);

  localparam int W  = OPERAND_WIDTH;
  localparam int NW = OPERAND_WIDTH - 1;
  localparam int KW = $clog2(OPERAND_WIDTH);

  logic [NW-1:0] rem_old;
  logic [NW-1:0] rem_cur;
  logic [W-1:0]  sa_old;
  logic [W-1:0]  sa_cur;
  logic [W-1:0]  sb_old;
  logic [W-1:0]  sb_cur;
  logic [KW-1:0] k;

  logic [W-1:0]  dsh;
  logic          fits;
  logic [W-1:0]  rem_diff;
  logic [NW-1:0] rem_red;
  logic [W-1:0]  sa_red;
  logic [W-1:0]  sb_red;

  // Shift the divisor and current coefficients by the running count and form the conditional subtraction
  always_comb begin
    dsh      = {1'b0, rem_cur} << k;
    fits     = {1'b0, rem_old} >= dsh;
    rem_diff = {1'b0, rem_old} - dsh;
    rem_red  = fits ? rem_diff[NW-1:0] : rem_old;
    sa_red   = fits ? (sa_old - (sa_cur << k)) : sa_old;
    sb_red   = fits ? (sb_old - (sb_cur << k)) : sb_old;
  end

  // Report status to the sequencer
  always_comb begin
    status.cur_zero = (rem_cur == '0);
    status.scale_ok = ({dsh, 1'b0} <= {2'b00, rem_old});
    status.k_zero   = (k == '0);
  end

  // Shift count: clear, count up while scaling, count down while reducing
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (ctrl.start) begin
      k <= '0;
    end else if (ctrl.scale) begin
      k <= k + KW'(1);
    end else if (ctrl.reduce && !status.k_zero) begin
      k <= k - KW'(1);
    end
  end

  // Remainders and coefficient pairs
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem_old <= first_value;
      rem_cur <= second_value;
      sa_old  <= W'(1);
      sa_cur  <= '0;
      sb_old  <= '0;
      sb_cur  <= W'(1);
    end else if (ctrl.reduce) begin
      if (status.k_zero) begin
        // last quotient bit: the reduced values become the new current pair
        rem_old <= rem_cur;
        rem_cur <= rem_red;
        sa_old  <= sa_cur;
        sa_cur  <= sa_red;
        sb_old  <= sb_cur;
        sb_cur  <= sb_red;
      end else begin
        rem_old <= rem_red;
        sa_old  <= sa_red;
        sb_old  <= sb_red;
      end
    end
  end

  assign divisor     = rem_old;
  assign coef_first  = sa_old;
  assign coef_second = sb_old;

endmodule

// ----- src/egcd_ctrl.sv -----
// Sequencer of the extended gcd: steps the shift-subtract unit through each quotient.
module egcd_ctrl import egcd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_take,
  input  logic         out_free,
  input  egcd_status_t status,
  output egcd_ctrl_t   ctrl,
  output logic         idle,
  output logic         emit
);

  egcd_state_t state;
  egcd_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = status.cur_zero ? ST_DONE : ST_SCALE;
      end
      ST_SCALE: begin
        if (!status.scale_ok) state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (status.k_zero) state_next = ST_CHECK;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl = '0;
    idle = 1'b0;
    emit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        idle      = 1'b1;
        ctrl.load = in_take;
      end
      ST_CHECK: begin
        ctrl.start = !status.cur_zero;
      end
      ST_SCALE: begin
        ctrl.scale = status.scale_ok;
      end
      ST_REDUCE: begin
        ctrl.reduce = 1'b1;
      end
      ST_DONE: begin
        emit = out_free;
      end
      default: begin
        idle = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/extended_gcd_iterative.sv -----
// Top level of the iterative extended gcd: stream ports, sequencer, unit and output register.
//
//  channel   | direction | payload (lowest bit first)
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | first_value, second_value, zero pad to bytes
//  m_axis    | out       | divisor, coef_first, coef_second, zero pad to bytes
//
// One transaction in gives one transaction out. Each Euclid step passes a check
// state, then the single shift-subtract unit scales up to shift k, the largest
// shift with the divisor still under the remainder, and reduces back down to zero.
// s_axis_tready is high only while the sequencer is idle. A result waits in the
// output register while m_axis_tready is low; the next operands are taken once it
// has left the sequencer. rst is synchronous and clears the sequencer and valid flag.
module extended_gcd_iterative import egcd_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              s_axis_tvalid,
  output logic                                              s_axis_tready,
  // first_value, second_value, zero pad
  input  logic [((2*(OPERAND_WIDTH-1)+7)/8)*8-1:0]          s_axis_tdata,
  output logic                                              m_axis_tvalid,
  input  logic                                              m_axis_tready,
  // divisor, coef_first, coef_second, zero pad
  output logic [((3*OPERAND_WIDTH-1+7)/8)*8-1:0]            m_axis_tdata
);

  localparam int W     = OPERAND_WIDTH;
  localparam int NW    = OPERAND_WIDTH - 1;
  localparam int OUT_W = ((3*OPERAND_WIDTH-1+7)/8)*8;
  localparam int PAD_W = OUT_W - (3*OPERAND_WIDTH-1);

  egcd_ctrl_t   ctrl;
  egcd_status_t status;
  logic         idle;
  logic         emit;
  logic         in_take;
  logic         out_free;
  logic [NW-1:0] divisor;
  logic [W-1:0]  coef_first;
  logic [W-1:0]  coef_second;

  assign s_axis_tready = idle;
  assign in_take       = s_axis_tvalid && idle;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  egcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_take  (in_take),
    .out_free (out_free),
    .status   (status),
    .ctrl     (ctrl),
    .idle     (idle),
    .emit     (emit)
  );

  egcd_unit #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_unit (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .first_value  (s_axis_tdata[NW-1:0]),
    .second_value (s_axis_tdata[2*NW-1:NW]),
    .status       (status),
    .divisor      (divisor),
    .coef_first   (coef_first),
    .coef_second  (coef_second)
  );

  // Output valid: set on a new result, drop when the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Output payload: hold until replaced by the next result
  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {{PAD_W{1'b0}}, coef_second, coef_first, divisor};
    end
  end

`ifndef SYNTHESIS
  // A new result never overwrites one still waiting
  assert property (@(posedge clk) disable iff (rst)
    emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result written over a pending output");

  // Taking operands closes the input until the result is produced
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input stayed open after a transaction");

  // After a result is written the sequencer is idle again
  assert property (@(posedge clk) disable iff (rst)
    emit |=> (s_axis_tready && m_axis_tvalid))
    else $error("sequencer not idle after emitting a result");
`endif

endmodule

// ----- bench/extended_gcd_iterative_test.sv -----
// Testbench for extended_gcd_iterative: stream stimulus, Bezout predictor and scoreboard.
`timescale 1ns / 100ps

module extended_gcd_iterative_test;

  localparam int OW     = 32;
  localparam int VAL_W  = OW - 1;
  localparam int S_W    = ((2 * (OW - 1) + 7) / 8) * 8;
  localparam int M_W    = ((3 * OW - 1 + 7) / 8) * 8;
  localparam int PAD_W  = S_W - 2 * VAL_W;
  localparam int N_RAND = 550;
  localparam int HOLD_LEN = 600;
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  typedef struct {
    logic [VAL_W-1:0] first_value;
    logic [VAL_W-1:0] second_value;
    logic [VAL_W-1:0] divisor;
    logic [OW-1:0]    coef_first;
    logic [OW-1:0]    coef_second;
  } bezout_t;

  // Hold expected gcd results in order and compare each output transaction
  class bezout_scoreboard;
    bezout_t     pending[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      mismatches = 0;
      checked    = 0;
    endfunction

    // Run the extended Euclid loop with 64-bit wrapping coefficients
    function bezout_t solve_bezout(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      bezout_t     res;
      logic [63:0] rem_old, rem_cur, quo, nrem;
      logic [63:0] sa_old, sa_cur, sb_old, sb_cur, ns, nt;
      rem_old = 64'(a);
      rem_cur = 64'(b);
      sa_old  = 64'd1;
      sa_cur  = 64'd0;
      sb_old  = 64'd0;
      sb_cur  = 64'd1;
      while (rem_cur != 64'd0) begin
        quo     = rem_old / rem_cur;
        nrem    = rem_old % rem_cur;
        ns      = sa_old - quo * sa_cur;
        nt      = sb_old - quo * sb_cur;
        rem_old = rem_cur;
        rem_cur = nrem;
        sa_old  = sa_cur;
        sa_cur  = ns;
        sb_old  = sb_cur;
        sb_cur  = nt;
      end
      res.first_value  = a;
      res.second_value = b;
      res.divisor      = rem_old[VAL_W-1:0];
      res.coef_first   = sa_old[OW-1:0];
      res.coef_second  = sb_old[OW-1:0];
      return res;
    endfunction

    // Note an accepted operand transaction; bits above the operands are ignored
    function void note_operands(logic [S_W-1:0] word);
      pending.push_back(solve_bezout(word[VAL_W-1:0], word[2*VAL_W-1:VAL_W]));
    endfunction

    // Check one result transaction against the oldest expectation
    function void check_result(logic [M_W-1:0] word);
      bezout_t          exp_res;
      logic [VAL_W-1:0] got_div;
      logic [OW-1:0]    got_cf, got_cs;
      got_div = word[VAL_W-1:0];
      got_cf  = word[VAL_W+OW-1:VAL_W];
      got_cs  = word[VAL_W+2*OW-1:VAL_W+OW];
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result divisor=%0d coef_first=%0d coef_second=%0d",
                 $time, got_div, $signed(got_cf), $signed(got_cs));
        return;
      end
      exp_res = pending.pop_front();
      checked++;
      if (got_div !== exp_res.divisor) begin
        mismatches++;
        $display("%0t: gcd(%0d,%0d) divisor expected %0d actual %0d", $time,
                 exp_res.first_value, exp_res.second_value, exp_res.divisor, got_div);
      end
      if (got_cf !== exp_res.coef_first) begin
        mismatches++;
        $display("%0t: gcd(%0d,%0d) coef_first expected %0d actual %0d", $time,
                 exp_res.first_value, exp_res.second_value,
                 $signed(exp_res.coef_first), $signed(got_cf));
      end
      if (got_cs !== exp_res.coef_second) begin
        mismatches++;
        $display("%0t: gcd(%0d,%0d) coef_second expected %0d actual %0d", $time,
                 exp_res.first_value, exp_res.second_value,
                 $signed(exp_res.coef_second), $signed(got_cs));
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [S_W-1:0] s_axis_tdata = '0;   // first_value, second_value, zero pad
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [M_W-1:0] m_axis_tdata;        // divisor, coef_first, coef_second, zero pad

  bezout_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned operands_sent = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_count = 0;

  extended_gcd_iterative #(.OPERAND_WIDTH(OW)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Drive the result ready: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_count != 0) begin
      m_axis_tready <= 1'b0;
      hold_count    <= hold_count - 1;
    end else if (hold_req && !hold_taken) begin
      m_axis_tready <= 1'b0;
      hold_taken    <= 1'b1;
      hold_count    <= HOLD_LEN;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata);
  end

  // Offer one operand transaction, with a random idle gap first
  task automatic send_operands(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                               logic [PAD_W-1:0] pad = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pad, b, a};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_operands(s_axis_tdata);
    operands_sent++;
  endtask

  // Consecutive Fibonacci numbers: the longest run of Euclid steps
  task automatic fib_pair(int unsigned k, output logic [VAL_W-1:0] lo,
                          output logic [VAL_W-1:0] hi);
    longint unsigned f0, f1, t;
    f0 = 1;
    f1 = 1;
    for (int unsigned i = 2; i < k; i++) begin
      t  = f0 + f1;
      f0 = f1;
      f1 = t;
    end
    lo = f0[VAL_W-1:0];
    hi = f1[VAL_W-1:0];
  endtask

  // Pick a random operand pair from a spread of shapes
  task automatic random_pair(output logic [VAL_W-1:0] a, output logic [VAL_W-1:0] b);
    int unsigned     shape, g, m;
    logic [VAL_W-1:0] t;
    shape = $urandom_range(99);
    if (shape < 30) begin
      a = VAL_W'($urandom);
      b = VAL_W'($urandom);
    end else if (shape < 45) begin
      a = VAL_W'($urandom >> $urandom_range(31));
      b = VAL_W'($urandom >> $urandom_range(31));
    end else if (shape < 55) begin
      a = VAL_W'($urandom_range(255));
      b = VAL_W'($urandom_range(255));
    end else if (shape < 67) begin
      fib_pair($urandom_range(46, 2), b, a);
    end else if (shape < 77) begin
      b = VAL_W'($urandom_range(65535, 1));
      m = $urandom_range(32'h7fff_ffff / b, 1);
      a = VAL_W'(b * m);
    end else if (shape < 89) begin
      g = $urandom_range(46340, 2);
      a = VAL_W'(g * $urandom_range(32'h7fff_ffff / g));
      b = VAL_W'(g * $urandom_range(32'h7fff_ffff / g));
    end else if (shape < 94) begin
      a = VAL_W'($urandom);
      b = $urandom_range(1) ? a : a - 1;
    end else begin
      a = VAL_W'($urandom);
      b = '0;
    end
    // swap order so either operand may be the larger
    if ($urandom_range(1)) begin
      t = a;
      a = b;
      b = t;
    end
  endtask

  initial begin
    logic [VAL_W-1:0] a, b;
    int unsigned      per_phase, drain;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero operands, extremes, stray pad bits, deepest Euclid chain
    send_operands(0, 0);
    send_operands(12345, 0);
    send_operands(VAL_MAX, 0);
    send_operands(0, 777);
    send_operands(0, VAL_MAX);
    send_operands(1, 1);
    send_operands(VAL_MAX, VAL_MAX);
    send_operands(VAL_MAX, 1);
    send_operands(1, VAL_MAX);
    send_operands(VAL_MAX, VAL_MAX - 1);
    send_operands(VAL_MAX - 1, VAL_MAX);
    send_operands(12, 18);
    send_operands(240, 46);
    send_operands(31'h4000_0000, 31'h2000_0000);
    send_operands(100, 75, '1);
    send_operands(0, 0, 2'b10);
    send_operands(VAL_MAX, 3, 2'b01);
    fib_pair(46, b, a);
    send_operands(a, b);
    send_operands(b, a);
    send_operands(31'h2aaa_aaaa, 31'h5555_5555);

    // Random: four idling phases, the first with a long receiver hold-off
    per_phase = N_RAND / 4;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 73; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 73; end
        default: begin send_idle_pct = 13; recv_idle_pct = 13; end
      endcase
      for (int unsigned i = 0; i < per_phase; i++) begin
        if (ph == 0 && i == 20)
          hold_req <= 1'b1;
        random_pair(a, b);
        send_operands(a, b);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results, then allow for one more solve
    drain = 0;
    while (sb.pending.size() != 0 && drain < 50000) begin
      @(posedge clk);
      drain++;
    end
    repeat (300) @(posedge clk);

    $display("Covered %0d operand pairs (%0d results checked): zero operands, extremes,",
             operands_sent, sb.checked);
    $display("Fibonacci chains, multiples, shared factors, idling and output back-pressure.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("extended_gcd_iterative test passed");
    end else begin
      $display("%0t: %0d mismatches, %0d results never arrived", $time,
               sb.mismatches, sb.pending.size());
      $display("extended_gcd_iterative test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5000000;
    $display("%0t: timeout with %0d results outstanding", $time, sb.pending.size());
    $display("extended_gcd_iterative test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/egcd_pkg.sv
src/egcd_unit.sv
src/egcd_ctrl.sv
src/extended_gcd_iterative.sv
bench/extended_gcd_iterative_test.sv
